/* hdl/trial_division_prime_test_core_defines.svh */
// assertion macros used by the trial division prime test rtl
`ifndef TRIAL_DIVISION_PRIME_TEST_CORE_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_CORE_DEFINES_SVH

// same-cycle implication under synchronous active-low reset
`define TDPT_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("tdpt assertion failed");

// next-cycle implication under synchronous active-low reset
`define TDPT_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("tdpt assertion failed");

`endif

/* hdl/tdpt_pkg.sv */
// package with widths, sequencer states and remainder unit interface types
package tdpt_pkg;

  localparam int VALUE_BITS = 32;
  localparam int DIV_BITS   = VALUE_BITS / 2 + 1;
  localparam int SQ_BITS    = VALUE_BITS + 2;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_SQ,
    ST_DIV,
    ST_DONE
  } tdpt_state_t;

  typedef struct packed {
    logic start;
  } rem_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_sts_t;

endpackage

/* hdl/tdpt_rem_unit.sv */
// shift-subtract remainder unit, one dividend bit per cycle
module tdpt_rem_unit
  import tdpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  rem_ctl_t              ctl,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [DIV_BITS-1:0]   divisor,
  output rem_sts_t              sts
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] dvd_r, dvd_nxt;
  logic [DIV_BITS-1:0]   dsr_r, dsr_nxt;
  logic [DIV_BITS-1:0]   rem_r, rem_nxt;
  logic [DIV_BITS:0]     shifted;
  logic [DIV_BITS:0]     diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign shifted = {rem_r, dvd_r[VALUE_BITS-1]};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (busy_r) begin
      dvd_nxt = {dvd_r[VALUE_BITS-2:0], 1'b0};
      if (!diff[DIV_BITS]) begin
        rem_nxt = diff[DIV_BITS-1:0];
      end else begin
        rem_nxt = shifted[DIV_BITS-1:0];
      end
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_BITS'(VALUE_BITS - 1);
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.zero = (rem_r == '0);

endmodule

/* hdl/trial_division_prime_test_core.sv */
// 0, 1, 2 and even candidates are settled in the classify state, odd ones go on to trial division
// odd divisors 3, 5, 7 ... are tried until one divides or its square exceeds the candidate
// each divisor takes ST_SQ, then 32 steps of the one shift-subtract remainder unit in ST_DIV
// one candidate at a time: a new beat is accepted only in the idle state
// a finished result waits in the output register while the next beat is accepted
// reset (rst_n low, synchronous) returns the sequencer to idle and drops any pending result
`include "trial_division_prime_test_core_defines.svh"

module trial_division_prime_test_core
  import tdpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] candidate
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] tested_value
  output logic        out_tuser   // [0] is_prime
);

  tdpt_state_t           state_r, state_nxt;
  logic [VALUE_BITS-1:0] n_r, n_nxt;
  logic [DIV_BITS-1:0]   d_r, d_nxt;
  logic [SQ_BITS-1:0]    sq_r, sq_nxt;
  logic                  verdict_r, verdict_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_data_r, out_data_nxt;
  logic                  out_prime_r, out_prime_nxt;
  rem_ctl_t              rem_ctl;
  rem_sts_t              rem_sts;

  tdpt_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rem_ctl),
    .dividend (n_r),
    .divisor  (d_r),
    .sts      (rem_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    verdict_r   <= verdict_nxt;
    out_data_r  <= out_data_nxt;
    out_prime_r <= out_prime_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    verdict_nxt   = verdict_r;
    out_data_nxt  = out_data_r;
    out_prime_nxt = out_prime_r;
    out_valid_nxt = out_valid_r && !out_tready;
    rem_ctl.start = 1'b0;
    in_tready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          n_nxt     = in_tdata[VALUE_BITS-1:0];
          state_nxt = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        if (n_r < VALUE_BITS'(2)) begin
          verdict_nxt = 1'b0;
          state_nxt   = ST_DONE;
        end else if (n_r == VALUE_BITS'(2)) begin
          verdict_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end else if (!n_r[0]) begin
          verdict_nxt = 1'b0;
          state_nxt   = ST_DONE;
        end else begin
          d_nxt     = DIV_BITS'(3);
          sq_nxt    = SQ_BITS'(9);
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (sq_r > SQ_BITS'(n_r)) begin
          verdict_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end else begin
          rem_ctl.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_sts.done) begin
          if (rem_sts.zero) begin
            verdict_nxt = 1'b0;
            state_nxt   = ST_DONE;
          end else begin
            d_nxt     = d_r + DIV_BITS'(2);
            sq_nxt    = sq_r + SQ_BITS'({d_r, 2'b00}) + SQ_BITS'(4);
            state_nxt = ST_SQ;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = n_r;
          out_prime_nxt = verdict_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 32'(out_data_r);
  assign out_tuser  = out_prime_r;

  `TDPT_ASSERT_IMP(a_rem_busy_in_div, clk, rst_n, rem_sts.busy, state_r == ST_DIV)
  `TDPT_ASSERT_IMP(a_square_tracks, clk, rst_n, state_r == ST_SQ,
                   sq_r == (SQ_BITS'(d_r) * SQ_BITS'(d_r)))
  `TDPT_ASSERT_IMP(a_prime_shape, clk, rst_n, out_valid_r && out_prime_r,
                   out_data_r[0] || (out_data_r == VALUE_BITS'(2)))
  `TDPT_ASSERT_NXT(a_start_divide, clk, rst_n,
                   (state_r == ST_SQ) && (sq_r <= SQ_BITS'(n_r)),
                   (state_r == ST_DIV) && rem_sts.busy)

endmodule

/* tb/testbench.sv */
// testbench for the trial division prime test core: directed table, then random candidates
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tdpt_pkg::*;

  localparam int CYCLE_LIMIT   = 4000000;
  localparam int DRAIN_CYCLES  = 64;
  localparam int RANDOM_ITEMS  = 80;
  localparam int DIRECTED_ROWS = 20;

  typedef struct packed {
    logic [31:0] tested_value;
    logic        is_prime;
  } verdict_t;

  typedef struct packed {
    logic [31:0] candidate;
    logic        typed;
    logic        typed_prime;
  } stim_row_t;

  // typed verdicts only where obvious, the rest go through the predictor
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{32'd0,          1'b1, 1'b0},
    '{32'd1,          1'b1, 1'b0},
    '{32'd2,          1'b1, 1'b1},
    '{32'd3,          1'b0, 1'b0},
    '{32'd4,          1'b1, 1'b0},
    '{32'd5,          1'b0, 1'b0},
    '{32'd9,          1'b0, 1'b0},
    '{32'd25,         1'b0, 1'b0},
    '{32'd49,         1'b0, 1'b0},
    '{32'd121,        1'b0, 1'b0},
    '{32'd97,         1'b0, 1'b0},
    '{32'd65537,      1'b0, 1'b0},
    '{32'd16777213,   1'b0, 1'b0},
    '{32'd16752649,   1'b0, 1'b0},
    '{32'hFFFF_FFFF,  1'b0, 1'b0},
    '{32'hFFFF_FFFE,  1'b1, 1'b0},
    '{32'h8000_0000,  1'b1, 1'b0},
    '{32'h8000_0001,  1'b0, 1'b0},
    '{32'hAAAA_AAAB,  1'b0, 1'b0},
    '{32'h5555_5555,  1'b0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;

  verdict_t    pending_verdicts [$];
  int          error_count = 0;
  int          cycle_count = 0;

  trial_division_prime_test_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] reduce_candidate(logic [31:0] raw);
    longint unsigned mask;
    if (VALUE_BITS >= 32) begin
      return raw;
    end
    mask = (64'd1 << VALUE_BITS) - 1;
    return raw & mask[31:0];
  endfunction

  function automatic logic primality_of(logic [31:0] n);
    longint unsigned val;
    longint unsigned div;
    val = n;
    if (val < 2) return 1'b0;
    if (val == 2) return 1'b1;
    if (val[0] == 1'b0) return 1'b0;
    for (div = 3; div <= val / div; div += 2) begin
      if (val % div == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // mostly small values; wide values get a small odd factor to keep the run short
  function automatic logic [31:0] draw_candidate();
    logic [31:0] raw;
    logic [31:0] factor;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 4095);
      4, 5, 6: return $urandom_range(4096, 262143);
      default: begin
        factor = 3 + 2 * $urandom_range(0, 5);
        raw = $urandom;
        raw = raw - raw % factor;
        if ($urandom_range(0, 1) == 1 && raw[0] == 1'b0 && raw >= factor) begin
          raw = raw - factor;
        end
        return raw;
      end
    endcase
  endfunction

  function automatic int draw_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 4);
  endfunction

  task automatic offer_candidate(logic [31:0] n, logic typed, logic typed_prime);
    int       gap;
    verdict_t verdict;
    gap = draw_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= n;
    do @(posedge clk); while (!in_tready);
    verdict.tested_value = reduce_candidate(n);
    verdict.is_prime     = typed ? typed_prime : primality_of(verdict.tested_value);
    pending_verdicts.push_back(verdict);
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (int idx = 0; idx < DIRECTED_ROWS; idx++) begin
      offer_candidate(directed_rows[idx].candidate, directed_rows[idx].typed,
                      directed_rows[idx].typed_prime);
    end
    for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
      offer_candidate(draw_candidate(), 1'b0, 1'b0);
    end
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("trial_division_prime_test_core verification clean");
    end else begin
      $display("trial_division_prime_test_core verification failed");
    end
    $finish;
  end

  initial begin
    verdict_t want;
    int       stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result beat with no verdict pending, actual value %0d prime %0b",
                 $time, out_tdata, out_tuser);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tdata !== want.tested_value) begin
          $display("%0t: tested_value mismatch, expected %0d actual %0d",
                   $time, want.tested_value, out_tdata);
          error_count++;
        end
        if (out_tuser !== want.is_prime) begin
          $display("%0t: is_prime mismatch for %0d, expected %0b actual %0b",
                   $time, want.tested_value, want.is_prime, out_tuser);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d verdicts still pending", $time, pending_verdicts.size());
      $display("trial_division_prime_test_core verification failed");
      $finish;
    end
  end

endmodule
